// File: rtl/core/rgbpal_pkg.sv
// shared types and constants for the rgb24 to palette index converter
package rgbpal_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COUNT_W = 9;

  localparam logic [7:0] BLUE_LIMIT  = 8'hdf;
  localparam logic [7:0] BLUE_ROUND  = 8'h20;
  localparam logic [7:0] GR_LIMIT    = 8'hef;
  localparam logic [7:0] GR_ROUND    = 8'h10;

  typedef enum logic [1:0] {
    CMD_COLLECT = 2'd0,
    CMD_MAP     = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] entry;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         index;
    logic [7:0]         pal_blue;
    logic [7:0]         pal_green;
    logic [7:0]         pal_red;
    logic               standard_palette;
    logic [COUNT_W-1:0] colour_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic start_read;
    logic search_step;
    logic hit_take;
    logic miss_take;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic overflow;
    logic in_range;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/rgbpal_datapath.sv
// palette store, search pointer, result composition and output register
module rgbpal_datapath #(
  parameter int PALETTE_DEPTH = rgbpal_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rgbpal_pkg::in_item_t   in_item,
  input  rgbpal_pkg::ctrl_cmd_t  ctrl,
  output rgbpal_pkg::dp_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rgbpal_pkg::out_item_t  out_item
);
  import rgbpal_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);

  logic [23:0]        mem [PALETTE_DEPTH];
  in_item_t           item;
  logic [23:0]        rdata;
  logic [CW-1:0]      ptr;
  logic               cmp_valid;
  logic [AW-1:0]      cmp_idx;
  logic [CW-1:0]      count;
  logic               overflow;
  logic [7:0]         res_idx;
  logic [23:0]        rgb;
  logic [COUNT_W-1:0] count_ext;
  logic               not_full;
  logic [7:0]         rb;
  logic [7:0]         rg;
  logic [7:0]         rr;
  out_item_t          result;

  assign rgb       = {item.red, item.green, item.blue};
  assign count_ext = COUNT_W'(count);
  assign not_full  = count < CW'(PALETTE_DEPTH);

  assign status.cmd       = item.cmd;
  assign status.overflow  = overflow;
  assign status.in_range  = COUNT_W'(item.entry) < count_ext;
  assign status.hit       = cmp_valid && (rdata == rgb);
  assign status.exhausted = (ptr >= count) && !cmp_valid;
  assign status.out_free  = !out_valid || !out_stall;

  // rounding for the fixed 3-3-2 palette
  assign rb = (item.blue  <= BLUE_LIMIT) ? item.blue  + BLUE_ROUND : item.blue;
  assign rg = (item.green <= GR_LIMIT)   ? item.green + GR_ROUND   : item.green;
  assign rr = (item.red   <= GR_LIMIT)   ? item.red   + GR_ROUND   : item.red;

  always_comb begin
    result                  = '0;
    result.standard_palette = overflow;
    result.colour_count     = count_ext;
    case (item.cmd)
      CMD_MAP: begin
        result.index = overflow ? {rb[7:6], rg[7:5], rr[7:5]} : res_idx;
      end
      CMD_READ: begin
        if (overflow) begin
          result.pal_red   = {item.entry[2:0], 5'b0};
          result.pal_green = {item.entry[5:3], 5'b0};
          result.pal_blue  = {item.entry[7:6], 6'b0};
        end else if (status.in_range) begin
          result.pal_blue  = rdata[7:0];
          result.pal_green = rdata[15:8];
          result.pal_red   = rdata[23:16];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        cmp_valid <= 1'b0;
      end else if (ctrl.search_step) begin
        cmp_valid <= ptr < count;
      end
      if (ctrl.clear) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (ctrl.miss_take && item.cmd == CMD_COLLECT) begin
        if (not_full) begin
          count <= count + CW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= in_item;
      ptr  <= '0;
    end else if (ctrl.search_step && ptr < count) begin
      ptr     <= ptr + CW'(1);
      cmp_idx <= ptr[AW-1:0];
    end
    if (ctrl.miss_take && item.cmd == CMD_COLLECT && not_full) begin
      mem[count[AW-1:0]] <= rgb;
    end
    if (ctrl.start_read) begin
      rdata <= mem[item.entry[AW-1:0]];
    end else if (ctrl.search_step) begin
      rdata <= mem[ptr[AW-1:0]];
    end
    if (ctrl.hit_take) begin
      res_idx <= 8'(cmp_idx);
    end else if (ctrl.miss_take) begin
      res_idx <= count_ext[7:0];
    end
    if (ctrl.out_load) begin
      out_item <= result;
    end
  end

endmodule

// File: rtl/core/rgbpal_ctrl.sv
// controller state machine sequencing dispatch, palette search and result hand-off
module rgbpal_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rgbpal_pkg::dp_status_t status,
  output rgbpal_pkg::ctrl_cmd_t  ctrl
);
  import rgbpal_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DISPATCH = 4'b0010,
    ST_SEARCH   = 4'b0100,
    ST_FINISH   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_FINISH;
        case (status.cmd)
          CMD_COLLECT, CMD_MAP: begin
            if (!status.overflow) begin
              state_next = ST_SEARCH;
            end
          end
          CMD_READ: begin
            ctrl.start_read = !status.overflow && status.in_range;
          end
          default: begin
            ctrl.clear = 1'b1;
          end
        endcase
      end
      ST_SEARCH: begin
        ctrl.search_step = 1'b1;
        if (status.hit) begin
          ctrl.hit_take = 1'b1;
          state_next    = ST_FINISH;
        end else if (status.exhausted) begin
          ctrl.miss_take = 1'b1;
          state_next     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/rgb24_to_palette_index_top.sv
// top level of the rgb24 to palette index converter
// usage:
//   in channel (in_valid, in_stall, in_item) takes one command transaction:
//   collect a color, map a pixel, read a palette entry or clear the palette.
//   out channel (out_valid, out_stall, out_item) returns exactly one result
//   transaction per command, in command order.
// sequencing:
//   one command is processed at a time; in_stall is high from acceptance
//   until the result is loaded into the output register.
//   read, clear and any command under overflow skip the palette search.
//   collect and map without overflow: the stored colors are scanned one per
//   cycle through the single read port of the palette memory until a hit
//   or until all colour_count stored entries have been compared.
// reset:
//   clears the color count and the overflow flag; the palette memory needs
//   no clearing pass, since entries at or above the count are never used.
// stall:
//   a result waits in the output register while out_stall is high; the next
//   command is accepted meanwhile and its result waits until the slot frees.
module rgb24_to_palette_index_top #(
  parameter int PALETTE_DEPTH = rgbpal_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbpal_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbpal_pkg::out_item_t out_item
);
  import rgbpal_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  rgbpal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  rgbpal_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.colour_count <= COUNT_W'(PALETTE_DEPTH))
    else $error("colour count above palette depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.standard_palette |->
      out_item.colour_count == COUNT_W'(PALETTE_DEPTH))
    else $error("standard palette without a full store");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in progress");

endmodule
